[src/htfc_pkg.sv]
// ----------------------------------------------------------------------------
// htfc_pkg: sensor reply check and conversion, shared types and constants
// Beat layouts, CRC polynomial, status mask, scale factors and offsets.
// ----------------------------------------------------------------------------
package htfc_pkg;

   // reply kind codes
   localparam logic KIND_TEMP  = 1'b0;
   localparam logic KIND_HUMID = 1'b1;

   // CRC-8, x^8+x^5+x^4+1, MSB first, init 0
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'h00;

   // two status bits sit at the bottom of the raw word
   localparam logic [15:0] STATUS_MASK = 16'hFFFC;

   // scale factors against 2^16
   localparam int MUL_W = 15;
   localparam int PROD_W = 16 + MUL_W;
   localparam logic [MUL_W-1:0] TEMP_MUL  = 15'd17572;
   localparam logic [MUL_W-1:0] HUMID_MUL = 15'd12500;

   localparam logic signed [15:0] TEMP_OFFSET  = 16'sd4685;
   localparam logic signed [15:0] HUMID_OFFSET = 16'sd600;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data_high;
      logic [7:0] data_low;
      logic [7:0] check_byte;
   } htfc_req_type;

   typedef struct packed {
      logic               check_ok;
      logic [15:0]        raw_word;
      logic signed [14:0] scaled_value;
      logic               kind_out;
   } htfc_rsp_type;

endpackage

[src/htfc_crc_byte.sv]
// ----------------------------------------------------------------------------
// htfc_crc_byte: one-byte CRC-8 update
// Folds one byte into the running CRC, eight shift/xor steps, unrolled.
// ----------------------------------------------------------------------------
module htfc_crc_byte (
   input  logic [7:0] crc_in,
   input  logic [7:0] data_in,
   output logic [7:0] crc_out
);

   always_comb begin
      logic [7:0] acc;
      acc = crc_in ^ data_in;
      for (int k = 0; k < 8; k++) begin
         if (acc[7]) begin
            acc = {acc[6:0], 1'b0} ^ htfc_pkg::CRC_POLY;
         end else begin
            acc = {acc[6:0], 1'b0};
         end
      end
      crc_out = acc;
   end

endmodule

[src/humidity_temp_frame_check_convert_top.sv]
// ----------------------------------------------------------------------------
// humidity_temp_frame_check_convert_top: sensor reply CRC check and scaling
// Checks CRC-8 over the two data bytes, masks the status bits and converts
// the raw word to hundredths of a degree C or of percent RH.
// ----------------------------------------------------------------------------
//
//   channel   ports                       direction  beat
//   request   start, busy, req_data       in         one sensor reply
//   response  rsp_valid, rsp_data         out        one checked, scaled word
//
// Three register stages: CRC of the high byte and constant select, then CRC
// of the low byte and the 16x15 multiply, then offset subtract and compare.
// A beat accepted with start is registered in each stage in turn and shows on
// rsp_* for one cycle; one beat per cycle sustained. busy is always low, and
// the receiver must take every response, which the block itself does not
// enforce; the pipeline never stalls. Synchronous reset clears the valid bits only.
module humidity_temp_frame_check_convert_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  htfc_pkg::htfc_req_type req_data,
   output logic                   rsp_valid,
   output htfc_pkg::htfc_rsp_type rsp_data
);

   // stage 1
   logic                          s1_valid_ff, s1_valid_in;
   logic [7:0]                    s1_crc_ff, s1_crc_in;
   logic [7:0]                    s1_lo_ff;
   logic [7:0]                    s1_chk_ff;
   logic [15:0]                   s1_raw_ff, s1_raw_in;
   logic                          s1_kind_ff;
   logic [htfc_pkg::MUL_W-1:0]    s1_mul_ff, s1_mul_in;
   // stage 2
   logic                          s2_valid_ff;
   logic [7:0]                    s2_crc_ff, s2_crc_in;
   logic [7:0]                    s2_chk_ff;
   logic [15:0]                   s2_raw_ff;
   logic                          s2_kind_ff;
   logic [htfc_pkg::PROD_W-1:0]   s2_prod_ff, s2_prod_in;
   // stage 3
   logic                          rsp_valid_ff;
   htfc_pkg::htfc_rsp_type        rsp_ff, rsp_in;

   logic signed [15:0]            offset_sel;
   logic signed [15:0]            scaled_full;

   assign busy = 1'b0;

   // ---- stage 1 ----
   htfc_crc_byte u_crc_high (
      .crc_in  (htfc_pkg::CRC_INIT),
      .data_in (req_data.data_high),
      .crc_out (s1_crc_in)
   );

   assign s1_valid_in = start && !busy;
   assign s1_raw_in   = {req_data.data_high, req_data.data_low} & htfc_pkg::STATUS_MASK;
   assign s1_mul_in   = (req_data.cmd == htfc_pkg::KIND_HUMID) ? htfc_pkg::HUMID_MUL
                                                               : htfc_pkg::TEMP_MUL;

   // ---- stage 2 ----
   htfc_crc_byte u_crc_low (
      .crc_in  (s1_crc_ff),
      .data_in (s1_lo_ff),
      .crc_out (s2_crc_in)
   );

   assign s2_prod_in = htfc_pkg::PROD_W'(s1_raw_ff) * htfc_pkg::PROD_W'(s1_mul_ff);

   // ---- stage 3 ----
   assign offset_sel  = (s2_kind_ff == htfc_pkg::KIND_HUMID) ? htfc_pkg::HUMID_OFFSET
                                                             : htfc_pkg::TEMP_OFFSET;
   // floor(prod / 2^16) is at most 17570, positive in 16 signed bits
   assign scaled_full = $signed({1'b0, s2_prod_ff[htfc_pkg::PROD_W-1:16]}) - offset_sel;

   always_comb begin
      rsp_in.check_ok     = (s2_crc_ff == s2_chk_ff);
      rsp_in.raw_word     = s2_raw_ff;
      rsp_in.scaled_value = scaled_full[14:0];
      rsp_in.kind_out     = s2_kind_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_crc_ff  <= s1_crc_in;
      s1_lo_ff   <= req_data.data_low;
      s1_chk_ff  <= req_data.check_byte;
      s1_raw_ff  <= s1_raw_in;
      s1_kind_ff <= req_data.cmd;
      s1_mul_ff  <= s1_mul_in;

      s2_crc_ff  <= s2_crc_in;
      s2_chk_ff  <= s1_chk_ff;
      s2_raw_ff  <= s1_raw_ff;
      s2_kind_ff <= s1_kind_ff;
      s2_prod_ff <= s2_prod_in;

      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---- assertions ----
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("accepted beat did not come out three cycles later");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 3))
      else $error("response strobe without a request");

   a_kind_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.kind_out == $past(req_data.cmd, 3)))
      else $error("kind echo does not match its request");

   a_raw_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.raw_word ==
                     {$past(req_data.data_high, 3), $past(req_data.data_low, 3) & 8'hFC}))
      else $error("raw word does not match its request");

endmodule

[tb/sv/htfc_reply_check_pkg.sv]
// ----------------------------------------------------------------------------
// htfc_reply_check_pkg: expected-reply bookkeeping for the sensor reply block
// Computes the CRC-8 verdict, masked raw word and scaled value for each
// accepted reply beat and checks the block's response beats in order.
// ----------------------------------------------------------------------------
package htfc_reply_check_pkg;
   import htfc_pkg::*;

   localparam logic [7:0]  SENSOR_POLY   = 8'h31;
   localparam logic [15:0] STATUS_CLEAR  = 16'hFFFC;
   localparam longint      TEMP_GAIN     = 17572;
   localparam longint      HUMID_GAIN    = 12500;
   localparam longint      TEMP_BIAS     = 4685;
   localparam longint      HUMID_BIAS    = 600;

   // CRC-8 over the two data bytes, MSB first, init 0, no final xor
   function automatic logic [7:0] sensor_crc8(logic [7:0] hi, logic [7:0] lo);
      logic [15:0] word;
      logic [7:0]  crc;
      word = {hi, lo};
      crc  = 8'h00;
      for (int b = 1; b >= 0; b--) begin
         crc = crc ^ word[b*8 +: 8];
         for (int k = 0; k < 8; k++) begin
            if (crc[7]) begin
               crc = {crc[6:0], 1'b0} ^ SENSOR_POLY;
            end else begin
               crc = {crc[6:0], 1'b0};
            end
         end
      end
      return crc;
   endfunction

   function automatic htfc_rsp_type convert_reply(htfc_req_type req);
      htfc_rsp_type exp_rsp;
      logic [15:0]  raw;
      longint       scaled;
      raw = {req.data_high, req.data_low} & STATUS_CLEAR;
      if (req.cmd == KIND_TEMP) begin
         scaled = ((longint'(raw) * TEMP_GAIN) >> 16) - TEMP_BIAS;
      end else begin
         scaled = ((longint'(raw) * HUMID_GAIN) >> 16) - HUMID_BIAS;
      end
      exp_rsp.check_ok     = (sensor_crc8(req.data_high, req.data_low) == req.check_byte);
      exp_rsp.raw_word     = raw;
      exp_rsp.scaled_value = scaled[14:0];
      exp_rsp.kind_out     = req.cmd;
      return exp_rsp;
   endfunction

   class reply_scoreboard;
      htfc_rsp_type expected_replies[$];
      int           error_count;
      int           reply_count;

      function new();
         error_count = 0;
         reply_count = 0;
      endfunction

      task report(string msg);
         $display("ERROR: reply %0d: %s", reply_count, msg);
         error_count++;
      endtask

      task note_reply(htfc_req_type req);
         expected_replies.push_back(convert_reply(req));
      endtask

      task check_reply(htfc_rsp_type got);
         htfc_rsp_type exp_rsp;
         if (expected_replies.size() == 0) begin
            report($sformatf("unexpected response beat %h", got));
         end else begin
            exp_rsp = expected_replies.pop_front();
            if (got.check_ok !== exp_rsp.check_ok)
               report($sformatf("check_ok %b, want %b", got.check_ok, exp_rsp.check_ok));
            if (got.raw_word !== exp_rsp.raw_word)
               report($sformatf("raw_word %h, want %h", got.raw_word, exp_rsp.raw_word));
            if (got.scaled_value !== exp_rsp.scaled_value)
               report($sformatf("scaled_value %0d, want %0d",
                                got.scaled_value, exp_rsp.scaled_value));
            if (got.kind_out !== exp_rsp.kind_out)
               report($sformatf("kind_out %b, want %b", got.kind_out, exp_rsp.kind_out));
         end
         reply_count++;
      endtask

      function int pending();
         return expected_replies.size();
      endfunction
   endclass

endpackage

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for the sensor reply check and conversion block
// Drives directed corner replies then random ones, mostly with a valid CRC,
// with random start gaps in some stretches; every response beat is checked in order.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import htfc_pkg::*;
   import htfc_reply_check_pkg::*;

   localparam int RANDOM_REPLIES = 400;
   localparam int STALL_LIMIT    = 1000;
   localparam int DRAIN_CYCLES   = 10;

   logic         clock = 1'b0;
   logic         reset;
   logic         start;
   logic         busy;
   htfc_req_type req_data;
   logic         rsp_valid;
   htfc_rsp_type rsp_data;

   reply_scoreboard reply_sb;
   bit              gaps_on;
   int              idle_cycles;

   humidity_temp_frame_check_convert_top u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // beat monitor and stall watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            reply_sb.note_reply(req_data);
         end
         if (rsp_valid) begin
            reply_sb.check_reply(rsp_data);
         end
         if ((start && !busy) || rsp_valid) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   function automatic htfc_req_type make_reply(logic kind, logic [15:0] word, bit good);
      htfc_req_type req;
      logic [7:0]   crc;
      req.cmd       = kind;
      req.data_high = word[15:8];
      req.data_low  = word[7:0];
      crc           = sensor_crc8(word[15:8], word[7:0]);
      if (good) begin
         req.check_byte = crc;
      end else if ($urandom_range(0, 1) == 0) begin
         req.check_byte = crc ^ (8'h01 << $urandom_range(0, 7));
      end else begin
         req.check_byte = 8'($urandom_range(0, 255));
      end
      return req;
   endfunction

   task automatic send_reply(htfc_req_type req);
      int gap;
      start    <= 1'b1;
      req_data <= req;
      do @(posedge clock); while (busy);
      gap = gaps_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         start    <= 1'b0;
         req_data <= htfc_req_type'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_fixed(logic kind, logic [15:0] word, logic [7:0] check_byte);
      htfc_req_type req;
      req.cmd        = kind;
      req.data_high  = word[15:8];
      req.data_low   = word[7:0];
      req.check_byte = check_byte;
      send_reply(req);
   endtask

   initial begin
      logic kind;
      reply_sb    = new();
      idle_cycles = 0;
      gaps_on     = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners, both reply kinds
      for (int k = 0; k < 2; k++) begin
         kind = (k == 0) ? KIND_TEMP : KIND_HUMID;
         send_reply(make_reply(kind, 16'h0000, 1'b1));
         send_reply(make_reply(kind, 16'hFFFF, 1'b1));
         send_reply(make_reply(kind, 16'hFFFC, 1'b1));
         send_reply(make_reply(kind, 16'h0003, 1'b1));   // status bits only
         send_reply(make_reply(kind, 16'h8000, 1'b1));
         send_reply(make_reply(kind, 16'h683A, 1'b1));
         send_fixed(kind, 16'h683A, 8'h00);             // bad check byte
         send_fixed(kind, 16'hFFFF, 8'hFF);
         send_reply(make_reply(kind, 16'h5A5A, 1'b0));
         gaps_on = 1'b1;
      end

      // random: mostly well-formed replies, gaps switched per stretch
      for (int n = 0; n < RANDOM_REPLIES; n++) begin
         if (n % 40 == 0) gaps_on = ($urandom_range(0, 2) != 0);
         send_reply(make_reply(1'($urandom_range(0, 1)),
                               16'($urandom_range(0, 65535)),
                               $urandom_range(0, 3) != 0));
      end
      start <= 1'b0;

      while (reply_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (reply_sb.error_count == 0 && reply_sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[humidity_temp_frame_check_convert_top.f]
src/htfc_pkg.sv
src/htfc_crc_byte.sv
src/humidity_temp_frame_check_convert_top.sv
tb/sv/htfc_reply_check_pkg.sv
tb/sv/tb_top.sv
